@@ src/wlm_pkg.sv @@
package wlm_pkg;

  // Link phase kept between ticks
  typedef enum logic [1:0] {
    LNK_START  = 2'd0,
    LNK_UP     = 2'd1,
    LNK_FADING = 2'd2,
    LNK_LOST   = 2'd3
  } link_phase_t;

  // WAN phase kept between ticks
  typedef enum logic [2:0] {
    WP_IDLE    = 3'd0,
    WP_DIALING = 3'd1,
    WP_ONLINE  = 3'd2,
    WP_OFFLINE = 3'd3,
    WP_FAILED  = 3'd4
  } wan_phase_t;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_BLINK = 2'd2
  } led_mode_t;

  // Sampled link status codes
  localparam logic [1:0] LS_DOWN = 2'd0;
  localparam logic [1:0] LS_UP   = 2'd1;

  // Sampled WAN status codes
  localparam logic [2:0] WS_INIT         = 3'd0;
  localparam logic [2:0] WS_CONNECTING   = 3'd1;
  localparam logic [2:0] WS_CONNECTED    = 3'd2;
  localparam logic [2:0] WS_DISCONNECTED = 3'd3;
  localparam logic [2:0] WS_DOWN         = 3'd4;

  // Configuration register indexes
  localparam logic REG_SHORT_CHECK = 1'b0;
  localparam logic REG_LONG_CHECK  = 1'b1;

  localparam int unsigned CFG_W = 8;
  localparam logic [CFG_W-1:0] SHORT_CHECK_RESET = 8'd1;
  localparam logic [CFG_W-1:0] LONG_CHECK_RESET  = 8'd12;

  typedef struct packed {
    logic [1:0] link_status;
    logic [2:0] wan_status;
    logic       restart_request;
  } in_item_t;

  typedef struct packed {
    logic       led_update;
    logic [1:0] led_mode;
    logic       stop_wan;
    logic       restart_wan;
    logic [1:0] link_state_now;
    logic [2:0] wan_state_now;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] short_check_ticks;
    logic [CFG_W-1:0] long_check_ticks;
  } cfg_t;

endpackage

@@ src/wlm_tracker.sv @@
module wlm_tracker #(
  parameter int TICK_COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wlm_pkg::in_item_t item,
  input  wlm_pkg::cfg_t     cfg,
  output wlm_pkg::out_item_t result
);
  import wlm_pkg::*;

  localparam int CMP_W = (TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W;
  localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = {TICK_COUNT_BITS{1'b1}};

  link_phase_t                link_phase, link_phase_next;
  wan_phase_t                 wan_phase, wan_phase_next;
  logic                       use_long_interval, use_long_interval_next;
  logic [TICK_COUNT_BITS-1:0] ticks_since_check, ticks_since_check_next;
  logic                       restart_pending, restart_pending_next;

  logic                       pend;
  logic [TICK_COUNT_BITS-1:0] cnt_base;
  logic [CFG_W-1:0]           interval;
  logic                       check_due;
  logic [2:0]                 wan_eff;
  logic                       led_set;
  led_mode_t                  led_val;
  logic                       stop, restart;

  always_comb begin
    pend                   = restart_pending | item.restart_request;
    link_phase_next        = link_phase;
    wan_phase_next         = wan_phase;
    use_long_interval_next = use_long_interval;
    restart_pending_next   = pend;
    cnt_base               = ticks_since_check;
    led_set                = 1'b0;
    led_val                = LED_OFF;
    stop                   = 1'b0;
    restart                = 1'b0;
    wan_eff                = item.wan_status;
    interval               = use_long_interval ? cfg.long_check_ticks : cfg.short_check_ticks;
    check_due              = (CMP_W'(ticks_since_check) >= CMP_W'(interval)) || pend;

    case (item.link_status)
      LS_DOWN: begin
        if (link_phase != LNK_LOST) begin
          stop                   = (link_phase == LNK_FADING);
          if (link_phase == LNK_UP) begin
            link_phase_next = LNK_FADING;
          end else begin
            link_phase_next = LNK_LOST;
          end
          led_set                = 1'b1;
          led_val                = LED_OFF;
          use_long_interval_next = 1'b0;
        end
      end
      LS_UP: begin
        if (link_phase == LNK_START) begin
          link_phase_next        = LNK_UP;
          led_set                = 1'b1;
          led_val                = LED_BLINK;
          use_long_interval_next = 1'b0;
        end else if (link_phase != LNK_UP) begin
          // regained from going down or down
          link_phase_next        = LNK_UP;
          led_set                = 1'b1;
          led_val                = LED_BLINK;
          use_long_interval_next = 1'b0;
          if (wan_phase == WP_IDLE) begin
            wan_phase_next = WP_DIALING;
          end else if (wan_phase != WP_DIALING) begin
            link_phase_next = LNK_START;
            wan_phase_next  = WP_IDLE;
            restart         = 1'b1;
          end
        end else if (check_due) begin
          cnt_base = '0;
          if (pend) begin
            restart_pending_next = 1'b0;
            if (wan_phase == WP_ONLINE) begin
              wan_eff = WS_CONNECTING;
            end
          end
          case (wan_eff)
            WS_INIT, WS_CONNECTING: begin
              if (wan_phase != WP_DIALING) begin
                wan_phase_next         = WP_DIALING;
                led_set                = 1'b1;
                led_val                = LED_BLINK;
                use_long_interval_next = 1'b0;
              end
            end
            WS_CONNECTED: begin
              if (wan_phase != WP_ONLINE) begin
                wan_phase_next         = WP_ONLINE;
                led_set                = 1'b1;
                led_val                = LED_ON;
                use_long_interval_next = 1'b1;
              end
            end
            WS_DISCONNECTED: begin
              if (wan_phase != WP_OFFLINE) begin
                wan_phase_next         = WP_OFFLINE;
                led_set                = 1'b1;
                led_val                = LED_OFF;
                use_long_interval_next = 1'b0;
              end
            end
            WS_DOWN: begin
              // only a lost connection counts
              if (wan_phase == WP_ONLINE) begin
                link_phase_next        = LNK_START;
                wan_phase_next         = WP_IDLE;
                led_set                = 1'b1;
                led_val                = LED_BLINK;
                use_long_interval_next = 1'b0;
                restart                = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    ticks_since_check_next = (cnt_base == TICK_MAX) ? cnt_base : cnt_base + 1'b1;

    result.led_update     = led_set;
    result.led_mode       = led_val;
    result.stop_wan       = stop;
    result.restart_wan    = restart;
    result.link_state_now = link_phase_next;
    result.wan_state_now  = wan_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase        <= LNK_START;
      wan_phase         <= WP_IDLE;
      use_long_interval <= 1'b0;
      ticks_since_check <= '0;
      restart_pending   <= 1'b0;
    end else if (step) begin
      link_phase        <= link_phase_next;
      wan_phase         <= wan_phase_next;
      use_long_interval <= use_long_interval_next;
      ticks_since_check <= ticks_since_check_next;
      restart_pending   <= restart_pending_next;
    end
  end

endmodule

@@ src/wan_link_led_monitor.sv @@
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_data  (link, WAN status, restart)
// out     | output    | out_valid / out_ready | out_data (LED, stop, restart, phases)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One tick per cycle while out_data is not stalled; a tick's result reaches out_data
// through the input register, then the state update into the result register.
// Synchronous reset restores the phases, counter, pending restart, interval select and the two intervals.
// A stalled output holds its result; the input register keeps taking ticks
// as long as the result register drains or is empty.
module wan_link_led_monitor #(
  parameter int TICK_COUNT_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  wlm_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output wlm_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [wlm_pkg::CFG_W-1:0] cfg_data
);
  import wlm_pkg::*;

  in_item_t  item;
  logic      item_valid;
  logic      advance;
  cfg_t      cfg;
  out_item_t result;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_check_ticks <= SHORT_CHECK_RESET;
      cfg.long_check_ticks  <= LONG_CHECK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT_CHECK: cfg.short_check_ticks <= cfg_data;
        REG_LONG_CHECK:  cfg.long_check_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wlm_tracker #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_tracker (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (item),
    .cfg   (cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import wlm_pkg::*;

  localparam int CNT_W = 8;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int NUM_PHASES = 5;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  wan_link_led_monitor #(
    .TICK_COUNT_BITS(CNT_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Supervisor state mirrored on the testbench side
  link_phase_t      link_ph;
  wan_phase_t       wan_ph;
  logic             long_sel;
  logic [CNT_W-1:0] tick_cnt;
  logic             restart_due;
  logic [CFG_W-1:0] short_ticks;
  logic [CFG_W-1:0] long_ticks;

  out_item_t led_q[$];
  int        fail_cnt;
  int        cycle_cnt;
  int        burst_left;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  function automatic out_item_t predict_tick(input in_item_t t);
    out_item_t        r;
    logic [2:0]       ws;
    logic [CFG_W-1:0] iv;
    r = '0;
    r.led_mode = LED_OFF;
    ws = t.wan_status;
    if (t.restart_request) restart_due = 1'b1;
    case (t.link_status)
      LS_DOWN: begin
        if (link_ph != LNK_LOST) begin
          if (link_ph == LNK_FADING) r.stop_wan = 1'b1;
          if (link_ph == LNK_UP) begin
            link_ph = LNK_FADING;
          end else begin
            link_ph = LNK_LOST;
          end
          r.led_update = 1'b1;
          r.led_mode = LED_OFF;
          long_sel = 1'b0;
        end
      end
      LS_UP: begin
        if (link_ph == LNK_START) begin
          link_ph = LNK_UP;
          r.led_update = 1'b1;
          r.led_mode = LED_BLINK;
          long_sel = 1'b0;
        end else if (link_ph != LNK_UP) begin
          // regained from going down or down
          link_ph = LNK_UP;
          r.led_update = 1'b1;
          r.led_mode = LED_BLINK;
          long_sel = 1'b0;
          if (wan_ph == WP_IDLE) begin
            wan_ph = WP_DIALING;
          end else if (wan_ph != WP_DIALING) begin
            link_ph = LNK_START;
            wan_ph = WP_IDLE;
            r.restart_wan = 1'b1;
          end
        end else begin
          iv = long_sel ? long_ticks : short_ticks;
          if (tick_cnt >= iv || restart_due) begin
            tick_cnt = '0;
            if (restart_due) begin
              restart_due = 1'b0;
              if (wan_ph == WP_ONLINE) ws = WS_CONNECTING;
            end
            case (ws)
              WS_INIT, WS_CONNECTING: begin
                if (wan_ph != WP_DIALING) begin
                  wan_ph = WP_DIALING;
                  r.led_update = 1'b1;
                  r.led_mode = LED_BLINK;
                  long_sel = 1'b0;
                end
              end
              WS_CONNECTED: begin
                if (wan_ph != WP_ONLINE) begin
                  wan_ph = WP_ONLINE;
                  r.led_update = 1'b1;
                  r.led_mode = LED_ON;
                  long_sel = 1'b1;
                end
              end
              WS_DISCONNECTED: begin
                if (wan_ph != WP_OFFLINE) begin
                  wan_ph = WP_OFFLINE;
                  r.led_update = 1'b1;
                  r.led_mode = LED_OFF;
                  long_sel = 1'b0;
                end
              end
              WS_DOWN: begin
                // lost connection: restart from scratch
                if (wan_ph == WP_ONLINE) begin
                  link_ph = LNK_START;
                  wan_ph = WP_IDLE;
                  r.led_update = 1'b1;
                  r.led_mode = LED_BLINK;
                  long_sel = 1'b0;
                  r.restart_wan = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
    if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
    r.link_state_now = link_ph;
    r.wan_state_now = wan_ph;
    return r;
  endfunction

  function automatic in_item_t rand_tick(input int rr_pct);
    in_item_t t;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 84) begin
      t.link_status = LS_UP;
    end else if (pick < 94) begin
      t.link_status = LS_DOWN;
    end else begin
      t.link_status = 2'($urandom_range(2, 3));
    end
    if ($urandom_range(0, 99) < 85) begin
      t.wan_status = 3'($urandom_range(0, 4));
    end else begin
      t.wan_status = 3'($urandom_range(5, 7));
    end
    t.restart_request = ($urandom_range(0, 99) < rr_pct);
    return t;
  endfunction

  task automatic add_row(input logic [1:0] ls, input logic [2:0] ws, input logic rr,
                         input bit typed, input out_item_t want);
    dir_row_t row;
    row.stim.link_status = ls;
    row.stim.wan_status = ws;
    row.stim.restart_request = rr;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // One tick transfer, with the burst/gap pattern on the sending side
  task automatic send_tick(input in_item_t t, input bit typed, input out_item_t want);
    int        gap;
    out_item_t pred;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    pred = predict_tick(t);
    led_q.push_back(typed ? want : pred);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (led_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_intervals(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] l);
    cfg_we <= 1'b1;
    cfg_index <= REG_SHORT_CHECK;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_LONG_CHECK;
    cfg_data <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    short_ticks = s;
    long_ticks = l;
  endtask

  // Result side: stall pattern from a rotating 8-bit ready mask, checks on each transfer
  initial begin
    logic [7:0] ready_mask;
    int         slot;
    out_item_t  exp_item;
    out_ready <= 1'b0;
    ready_mask = 8'hFF;
    slot = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (led_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        end else begin
          exp_item = led_q.pop_front();
          if (out_data !== exp_item) begin
            fail_cnt++;
            $display("%0t: result mismatch: expected %h, actual %h",
                     $time, exp_item, out_data);
          end
        end
      end
      slot++;
      if (slot % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_mask = 8'hFF;
          1: ready_mask = 8'($urandom);
          2: ready_mask = 8'h11;
          default: ready_mask = 8'($urandom) | 8'h81;
        endcase
      end
      out_ready <= ready_mask[slot % 8];
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, led_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int               ph;
    int               n;
    in_item_t         t;
    out_item_t        none;
    int               phase_items[NUM_PHASES];
    int               phase_rr[NUM_PHASES];
    logic [CFG_W-1:0] phase_short[NUM_PHASES];
    logic [CFG_W-1:0] phase_long[NUM_PHASES];

    phase_items = '{150, 150, 200, 125, 125};
    phase_rr    = '{10, 10, 1, 5, 5};
    phase_short = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd7};
    phase_long  = '{8'd12, 8'd0, 8'd255, 8'd1, 8'd30};
    none = '0;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SHORT_CHECK;
    cfg_data <= '0;
    burst_left = 0;

    link_ph = LNK_START;
    wan_ph = WP_IDLE;
    long_sel = 1'b0;
    tick_cnt = '0;
    restart_due = 1'b0;
    short_ticks = SHORT_CHECK_RESET;
    long_ticks = LONG_CHECK_RESET;

    // first tick after reset, then link read errors that change nothing
    add_row(LS_UP, WS_INIT, 1'b0, 1'b1,
            {1'b1, LED_BLINK, 1'b0, 1'b0, LNK_UP, WP_IDLE});
    add_row(2'd2, 3'd7, 1'b0, 1'b1,
            {1'b0, LED_OFF, 1'b0, 1'b0, LNK_UP, WP_IDLE});
    add_row(2'd3, 3'd5, 1'b0, 1'b1,
            {1'b0, LED_OFF, 1'b0, 1'b0, LNK_UP, WP_IDLE});
    add_row(LS_UP, WS_CONNECTED, 1'b0, 1'b0, none);
    add_row(LS_UP, WS_CONNECTED, 1'b0, 1'b0, none);
    // restart notice while connected forces a reconnect
    add_row(LS_UP, WS_DOWN, 1'b1, 1'b0, none);
    add_row(LS_UP, WS_DISCONNECTED, 1'b0, 1'b0, none);
    // WAN down without a connection
    add_row(LS_UP, WS_DOWN, 1'b0, 1'b0, none);
    add_row(LS_UP, 3'd6, 1'b0, 1'b0, none);
    add_row(LS_UP, 3'd5, 1'b1, 1'b0, none);
    add_row(LS_UP, WS_CONNECTED, 1'b0, 1'b0, none);
    // regain from going down while connected
    add_row(LS_DOWN, WS_CONNECTED, 1'b0, 1'b0, none);
    add_row(LS_UP, WS_INIT, 1'b0, 1'b0, none);
    add_row(LS_DOWN, WS_INIT, 1'b0, 1'b0, none);
    add_row(LS_DOWN, WS_INIT, 1'b0, 1'b0, none);
    add_row(LS_UP, WS_DISCONNECTED, 1'b0, 1'b0, none);
    // two down ticks in a row give the stop
    add_row(LS_DOWN, WS_CONNECTING, 1'b0, 1'b0, none);
    add_row(LS_DOWN, WS_CONNECTING, 1'b0, 1'b0, none);
    add_row(LS_UP, WS_CONNECTING, 1'b0, 1'b0, none);
    add_row(LS_UP, 3'd7, 1'b1, 1'b0, none);
    add_row(LS_UP, WS_CONNECTING, 1'b0, 1'b0, none);
    add_row(LS_UP, WS_INIT, 1'b0, 1'b0, none);
    // notice latched while the link is down
    add_row(LS_DOWN, WS_CONNECTED, 1'b1, 1'b0, none);
    add_row(2'd2, WS_CONNECTED, 1'b0, 1'b0, none);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k])
      send_tick(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph > 0) write_intervals(phase_short[ph], phase_long[ph]);
      for (n = 0; n < phase_items[ph]; n++) begin
        // in the first phase only, hold off once mid-phase until the result side has caught up
        if (ph == 0 && n == phase_items[ph] / 2) drain();
        t = rand_tick(phase_rr[ph]);
        send_tick(t, 1'b0, none);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
